/* rtl/core/pdt_pkg.sv */
package pdt_pkg;

    // Coordinate format and squared distance format
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int SQ_W      = 64;

    // Starting minimum: 100 squared units, saturated when it does not fit
    localparam logic [SQ_W-1:0] SQ_CAP = (2 * FRAC_BITS > 57) ? {SQ_W{1'b1}}
                                         : (64'd100 << (2 * FRAC_BITS));

    // Threshold register
    localparam int              TOL_W     = 39;
    localparam logic [TOL_W-1:0] TOL_RESET = 39'd429496730;

    // Register map: register index taken from paddr[3]
    localparam int         CFG_AW     = 4;
    localparam int         CFG_DW     = 64;
    localparam logic [0:0] REG_TOL_SQ = 1'b0;

    // Result field widths
    localparam int SLOT_W = 8;
    localparam int UCNT_W = 9;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } t_sts;

endpackage

/* rtl/core/pdt_ram.sv */
module pdt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/pdt_ctrl.sv */
module pdt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pdt_pkg::t_sts i_sts,
    output pdt_pkg::t_cmd o_cmd
);

    pdt_pkg::t_state r_state;
    pdt_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pdt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = i_sts.cnt_zero ? pdt_pkg::S_COMMIT : pdt_pkg::S_SCAN;
                end
            end
            pdt_pkg::S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = pdt_pkg::S_DRAIN;
                end
            end
            pdt_pkg::S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = pdt_pkg::S_COMMIT;
                end
            end
            pdt_pkg::S_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = pdt_pkg::S_IDLE;
                end
            end
            default: n_state = pdt_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready      = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            pdt_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            pdt_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            pdt_pkg::S_DRAIN: begin
            end
            pdt_pkg::S_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/core/pdt_dp.sv */
module pdt_dp #(
    parameter int MAX_POINTS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pdt_pkg::t_cmd               i_cmd,
    output pdt_pkg::t_sts               o_sts,
    input  logic [pdt_pkg::TOL_W-1:0]   i_tol_sq,
    input  logic [pdt_pkg::COORD_W-1:0] i_point_x,
    input  logic [pdt_pkg::COORD_W-1:0] i_point_y,
    input  logic                        i_last,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_kept,
    output logic [pdt_pkg::SLOT_W-1:0]  o_slot,
    output logic [pdt_pkg::UCNT_W-1:0]  o_unique_count,
    output logic                        o_dropped_full,
    output logic                        o_set_done
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int XW = pdt_pkg::COORD_W;
    localparam int SW = pdt_pkg::SQ_W;

    // Item registers
    logic signed [XW-1:0] r_px;
    logic signed [XW-1:0] r_py;
    logic                 r_last;
    logic [CW-1:0]        r_cnt;
    logic [IW-1:0]        r_idx;
    logic [SW-1:0]        r_best;

    // Distance pipeline
    logic                 r_v1, r_v2, r_v3, r_v4;
    logic [XW-1:0]        r_dx, r_dy;
    logic [SW-1:0]        r_sqx, r_sqy;
    logic [SW-1:0]        r_sum;

    // Result register
    logic                      r_out_valid;
    logic                      r_kept;
    logic [pdt_pkg::SLOT_W-1:0] r_slot;
    logic [pdt_pkg::UCNT_W-1:0] r_ucnt;
    logic                      r_drop;
    logic                      r_done;

    logic [2*XW-1:0]      ram_rdata;
    logic signed [XW-1:0] tx, ty;
    logic signed [XW:0]   dx, dy;
    logic [SW:0]          sum_w;
    logic                 keep, full, store;
    logic [CW-1:0]        cnt_after;

    pdt_ram #(
        .WIDTH (2 * XW),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && store),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata ({r_py, r_px}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Differences at 33 bits; their magnitudes are always below 2^32
    assign tx = ram_rdata[XW-1:0];
    assign ty = ram_rdata[2*XW-1:XW];
    assign dx = {r_px[XW-1], r_px} - {tx[XW-1], tx};
    assign dy = {r_py[XW-1], r_py} - {ty[XW-1], ty};

    // Saturating sum of squares
    assign sum_w = {1'b0, r_sqx} + {1'b0, r_sqy};

    // Keep decision and table update
    assign keep      = (r_cnt == '0) || (r_best > SW'(i_tol_sq));
    assign full      = (r_cnt == CW'(MAX_POINTS));
    assign store     = keep && !full;
    assign cnt_after = store ? r_cnt + CW'(1) : r_cnt;

    // Capture the item and advance the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px   <= i_point_x;
            r_py   <= i_point_y;
            r_last <= i_last;
            r_idx  <= '0;
            r_best <= pdt_pkg::SQ_CAP;
        end else begin
            if (i_cmd.scan) begin
                r_idx <= r_idx + IW'(1);
            end
            if (r_v4 && (r_sum < r_best)) begin
                r_best <= r_sum;
            end
        end
        r_dx  <= dx[XW] ? XW'(-dx) : dx[XW-1:0];
        r_dy  <= dy[XW] ? XW'(-dy) : dy[XW-1:0];
        r_sqx <= SW'(r_dx) * SW'(r_dx);
        r_sqy <= SW'(r_dy) * SW'(r_dy);
        r_sum <= sum_w[SW] ? {SW{1'b1}} : sum_w[SW-1:0];
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Stored count, cleared after the last point of a set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.commit) begin
            r_cnt <= r_last ? '0 : cnt_after;
        end
    end

    // Result register, freed when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_kept <= store;
            r_slot <= store ? pdt_pkg::SLOT_W'(r_cnt) : '0;
            r_ucnt <= pdt_pkg::UCNT_W'(cnt_after);
            r_drop <= keep && full;
            r_done <= r_last;
        end
    end

    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.scan_last = (CW'(r_idx) + CW'(1) == r_cnt);
    assign o_sts.pipe_busy = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_kept         = r_kept;
    assign o_slot         = r_slot;
    assign o_unique_count = r_ucnt;
    assign o_dropped_full = r_drop;
    assign o_set_done     = r_done;

endmodule

/* rtl/core/point_dedup_tolerance.sv */
// One point at a time: the input beat is captured, scanned against every point stored in the set
// through the table's single read port and the distance pipeline, drained, then committed to the
// result register (the first point of a set goes straight to commit); no new point is taken until then.
// Reset (synchronous, active low) clears the controller, the stored count, the pipeline and result
// valid bits and tol_sq (to 429496730); the point table is not cleared and needs no pass.
module point_dedup_tolerance #(
    parameter int MAX_POINTS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // point_x [31:0], point_y [63:32]
    input  logic [63:0]                 s_axis_tdata,
    input  logic                        s_axis_tlast,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // kept [0], slot [8:1], unique_count [17:9], dropped_full [18], zero [23:19]
    output logic [23:0]                 m_axis_tdata,
    output logic                        m_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdt_pkg::CFG_AW-1:0]  paddr,
    input  logic [pdt_pkg::CFG_DW-1:0]  pwdata,
    output logic [pdt_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);

    logic [pdt_pkg::TOL_W-1:0]  r_tol_sq;
    pdt_pkg::t_cmd              cmd;
    pdt_pkg::t_sts              sts;
    logic                       kept, dropped_full;
    logic [pdt_pkg::SLOT_W-1:0] slot;
    logic [pdt_pkg::UCNT_W-1:0] unique_count;
    logic                       cfg_wr;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[3] == pdt_pkg::REG_TOL_SQ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol_sq <= pdt_pkg::TOL_RESET;
        end else if (cfg_wr) begin
            r_tol_sq <= pwdata[pdt_pkg::TOL_W-1:0];
        end
    end

    assign prdata = (paddr[3] == pdt_pkg::REG_TOL_SQ)
                    ? pdt_pkg::CFG_DW'(r_tol_sq) : '0;

    pdt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pdt_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_tol_sq       (r_tol_sq),
        .i_point_x      (s_axis_tdata[31:0]),
        .i_point_y      (s_axis_tdata[63:32]),
        .i_last         (s_axis_tlast),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_kept         (kept),
        .o_slot         (slot),
        .o_unique_count (unique_count),
        .o_dropped_full (dropped_full),
        .o_set_done     (m_axis_tlast)
    );

    // Pack the result beat
    assign m_axis_tdata = {5'b0, dropped_full, unique_count, slot, kept};

    // A point is never both stored and dropped
    a_kept_xor_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(kept && dropped_full))
        else $error("kept and dropped_full both set");

    // A point that is not stored reports slot zero
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !kept) |-> (slot == '0))
        else $error("slot set for a point that was not stored");

    // The distance pipeline is empty whenever a new point can enter
    a_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !sts.pipe_busy)
        else $error("distance pipeline busy while idle");

    // One point at a time: no second beat right after an accepted one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a point is in work");

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 8;
    localparam int TAB_DEPTH    = 256;
    // Limit for the whole run, with a wide margin over the slowest correct run
    localparam int CYCLE_LIMIT  = 2_000_000;
    // One scan over a full table plus pipeline, with margin
    localparam int DRAIN_CYCLES = TAB_DEPTH + 32;
    localparam int PHASE_POINTS = 72;
    localparam int HOLD_CYCLES  = 600;
    localparam int NEAR_WINDOW  = 1 << 22;

    localparam logic [pdt_pkg::CFG_AW-1:0] TOL_ADDR = {pdt_pkg::REG_TOL_SQ, 3'b000};
    // Threshold equal to the starting minimum
    localparam logic [pdt_pkg::TOL_W-1:0]  TOL_TOP_VAL = 39'd429496729600;

    typedef enum int {
        TOL_DEFAULT,
        TOL_ZERO,
        TOL_FINE,
        TOL_TOP,
        TOL_ANY,
        TOL_PICKS
    } t_tol_pick;

    typedef struct packed {
        logic signed [pdt_pkg::COORD_W-1:0] x;
        logic signed [pdt_pkg::COORD_W-1:0] y;
        logic                               last;
    } t_point;

    typedef struct packed {
        logic                       kept;
        logic [pdt_pkg::SLOT_W-1:0] slot;
        logic [pdt_pkg::UCNT_W-1:0] ucnt;
        logic                       dropped;
        logic                       done;
    } t_verdict;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    // point_x [31:0], point_y [63:32]
    logic [63:0]                   s_axis_tdata  = '0;
    logic                          s_axis_tlast  = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // kept [0], slot [8:1], unique_count [17:9], dropped_full [18], zero [23:19]
    logic [23:0]                   m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic                          psel          = 1'b0;
    logic                          penable       = 1'b0;
    logic                          pwrite        = 1'b0;
    logic [pdt_pkg::CFG_AW-1:0]    paddr         = '0;
    logic [pdt_pkg::CFG_DW-1:0]    pwdata        = '0;
    logic [pdt_pkg::CFG_DW-1:0]    prdata;
    logic                          pready;

    // Predictor state: stored points of the current set and the threshold
    logic signed [pdt_pkg::COORD_W-1:0] seen_x [TAB_DEPTH];
    logic signed [pdt_pkg::COORD_W-1:0] seen_y [TAB_DEPTH];
    int                                 seen_count  = 0;
    logic [pdt_pkg::TOL_W-1:0]          tol_sq_cur  = pdt_pkg::TOL_RESET;

    t_point                             points_to_send [$];
    t_verdict                           verdicts_due [$];
    t_point                             beat_point;
    t_point                             next_point;
    t_verdict                           want;
    logic signed [pdt_pkg::COORD_W-1:0] set_x [$];
    logic signed [pdt_pkg::COORD_W-1:0] set_y [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int points_queued = 0;
    int mismatches    = 0;
    int cycles        = 0;

    point_dedup_tolerance #(
        .MAX_POINTS(TAB_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Nearest stored point decides whether the new point is unique
    function automatic t_verdict classify_point(t_point p);
        t_verdict                         v;
        logic [pdt_pkg::SQ_W-1:0]         nearest;
        logic [pdt_pkg::SQ_W-1:0]         sq_x;
        logic [pdt_pkg::SQ_W-1:0]         sq_y;
        logic [pdt_pkg::SQ_W-1:0]         sq_dist;
        logic [pdt_pkg::SQ_W:0]           sum;
        logic signed [pdt_pkg::COORD_W:0] dx;
        logic signed [pdt_pkg::COORD_W:0] dy;
        logic [pdt_pkg::COORD_W:0]        mx;
        logic [pdt_pkg::COORD_W:0]        my;
        logic                             keep;
        int                               j;
        v    = '0;
        keep = 1'b1;
        if (seen_count != 0) begin
            nearest = pdt_pkg::SQ_CAP;
            for (j = 0; j < seen_count; j++) begin
                dx   = {p.x[pdt_pkg::COORD_W-1], p.x}
                       - {seen_x[j][pdt_pkg::COORD_W-1], seen_x[j]};
                dy   = {p.y[pdt_pkg::COORD_W-1], p.y}
                       - {seen_y[j][pdt_pkg::COORD_W-1], seen_y[j]};
                mx   = dx[pdt_pkg::COORD_W] ? -dx : dx;
                my   = dy[pdt_pkg::COORD_W] ? -dy : dy;
                sq_x = pdt_pkg::SQ_W'(mx) * pdt_pkg::SQ_W'(mx);
                sq_y = pdt_pkg::SQ_W'(my) * pdt_pkg::SQ_W'(my);
                // saturate the sum of squares at the top of 64 bits
                sum  = {1'b0, sq_x} + {1'b0, sq_y};
                sq_dist = sum[pdt_pkg::SQ_W] ? {pdt_pkg::SQ_W{1'b1}}
                                             : sum[pdt_pkg::SQ_W-1:0];
                if (sq_dist < nearest)
                    nearest = sq_dist;
            end
            keep = nearest > {{(pdt_pkg::SQ_W-pdt_pkg::TOL_W){1'b0}}, tol_sq_cur};
        end
        if (keep) begin
            if (seen_count < TAB_DEPTH) begin
                seen_x[seen_count] = p.x;
                seen_y[seen_count] = p.y;
                v.kept = 1'b1;
                v.slot = pdt_pkg::SLOT_W'(seen_count);
                seen_count++;
            end else begin
                // table full: lose the point, flag it
                v.dropped = 1'b1;
            end
        end
        v.ucnt = pdt_pkg::UCNT_W'(seen_count);
        v.done = p.last;
        if (p.last)
            seen_count = 0;
        return v;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // Input driver: present queued points, predict each beat as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                verdicts_due = {verdicts_due, classify_point(beat_point)};
            if (!s_axis_tvalid || s_axis_tready) begin
                if (points_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_point = points_to_send.pop_front();
                    beat_point    <= next_point;
                    s_axis_tdata  <= {next_point.y, next_point.x};
                    s_axis_tlast  <= next_point.last;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side ready: random stalls, or a long hold when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen     <= hold_token;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each result beat with the oldest predicted verdict
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdicts_due.size() == 0) begin
                $error("result beat with no point pending: tdata %0h", m_axis_tdata);
                mismatches++;
            end else begin
                want = verdicts_due.pop_front();
                check_field("kept", want.kept, m_axis_tdata[0]);
                check_field("slot", want.slot, m_axis_tdata[8:1]);
                check_field("unique_count", want.ucnt, m_axis_tdata[17:9]);
                check_field("dropped_full", want.dropped, m_axis_tdata[18]);
                check_field("tdata pad", 0, m_axis_tdata[23:19]);
                check_field("set_done", want.done, m_axis_tlast);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void add_point(logic signed [pdt_pkg::COORD_W-1:0] x,
                                      logic signed [pdt_pkg::COORD_W-1:0] y,
                                      logic last);
        t_point p;
        p.x    = x;
        p.y    = y;
        p.last = last;
        points_to_send = {points_to_send, p};
        points_queued++;
    endfunction

    // Offset on the scale of the threshold, from tiny to beyond the cap
    function automatic logic signed [pdt_pkg::COORD_W-1:0] jitter();
        int lim;
        int mag;
        case ($urandom_range(0, 3))
            0:       lim = 3;
            1:       lim = 300;
            2:       lim = 40000;
            default: lim = 1 << 20;
        endcase
        mag = $urandom_range(0, lim);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic int pick_set_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 12);
        else if (r < 95)
            return $urandom_range(13, 40);
        return $urandom_range(41, 90);
    endfunction

    // Queue one set: fresh points, exact repeats and near misses of earlier ones
    function automatic void queue_set(int n, int fresh_lead);
        logic signed [pdt_pkg::COORD_W-1:0] x;
        logic signed [pdt_pkg::COORD_W-1:0] y;
        int                                 k;
        int                                 j;
        int                                 pick;
        set_x.delete();
        set_y.delete();
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (set_x.size() == 0 || k < fresh_lead || pick < 45) begin
                if ($urandom_range(0, 1)) begin
                    x = $urandom;
                    y = $urandom;
                end else begin
                    x = $urandom_range(0, NEAR_WINDOW) - NEAR_WINDOW / 2;
                    y = $urandom_range(0, NEAR_WINDOW) - NEAR_WINDOW / 2;
                end
            end else begin
                j = $urandom_range(0, set_x.size() - 1);
                x = set_x[j];
                y = set_y[j];
                if (pick >= 60) begin
                    x = x + jitter();
                    y = y + jitter();
                end
            end
            set_x = {set_x, x};
            set_y = {set_y, y};
            add_point(x, y, k == n - 1);
        end
    endfunction

    function automatic logic [pdt_pkg::TOL_W-1:0] choose_tol(t_tol_pick pick);
        logic [63:0] v;
        case (pick)
            TOL_DEFAULT: v = pdt_pkg::TOL_RESET;
            TOL_ZERO:    v = 0;
            TOL_FINE:    v = $urandom_range(0, 1 << 30);
            TOL_TOP:     v = TOL_TOP_VAL;
            default:     v = 64'($urandom) * $urandom_range(0, 100);
        endcase
        return v[pdt_pkg::TOL_W-1:0];
    endfunction

    // Hold until every queued point is sent and every verdict has come back
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (points_to_send.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0);
    endtask

    // Write the threshold, then read it straight back
    task automatic write_tol(logic [pdt_pkg::TOL_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TOL_ADDR;
        pwdata  <= {{(pdt_pkg::CFG_DW-pdt_pkg::TOL_W){1'b0}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        tol_sq_cur = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata[pdt_pkg::TOL_W-1:0] !== val) begin
            $error("tol_sq mismatch: expected %0d, got %0d", val,
                   prdata[pdt_pkg::TOL_W-1:0]);
            mismatches++;
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int reg_i;
        int ph;
        int start;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Threshold at its reset value: first point, repeat, both sides of the
        // threshold, extreme corners with a saturating sum of squares
        send_idle_pct = 17;
        recv_idle_pct = 79;
        add_point(0, 0, 1'b0);
        add_point(0, 0, 1'b0);
        add_point(20724, 0, 1'b0);
        add_point(0, 20725, 1'b0);
        add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        add_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
        add_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
        add_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
        wait_idle();

        // Zero threshold: only exact repeats are dropped
        write_tol(0);
        add_point(5, 5, 1'b0);
        add_point(5, 5, 1'b0);
        add_point(5, 6, 1'b0);
        add_point(5, 6, 1'b1);
        wait_idle();

        // Distance exactly at the threshold is not unique
        write_tol(39'd400000000);
        add_point(-100, -100, 1'b0);
        add_point(19900, -100, 1'b0);
        add_point(-100, 19901, 1'b0);
        add_point(-100, -100, 1'b1);
        wait_idle();

        // Threshold at the cap: only the first point of a set survives;
        // pause the sender mid-set until everything has drained
        write_tol(TOL_TOP_VAL);
        add_point(0, 0, 1'b0);
        add_point(32'sh7FFF_FFFF, 0, 1'b0);
        wait_idle();
        add_point(1000, 1000, 1'b0);
        add_point(-5, -5, 1'b1);

        // Random sets under each threshold, through three stall regimes
        for (reg_i = 0; reg_i < 3; reg_i++) begin
            send_idle_pct = (reg_i == 0) ? 17 : (reg_i == 1) ? 79 : 0;
            recv_idle_pct = (reg_i == 0) ? 79 : (reg_i == 1) ? 17 : 0;
            for (ph = 0; ph < TOL_PICKS; ph++) begin
                wait_idle();
                write_tol(choose_tol(t_tol_pick'(ph)));
                start = points_queued;
                // fill the table past its end once at a loose and once at a zero threshold
                if ((reg_i == 0 && ph == TOL_DEFAULT) || (reg_i == 2 && ph == TOL_ZERO))
                    queue_set(TAB_DEPTH + 40, TAB_DEPTH + 10);
                while (points_queued - start < PHASE_POINTS)
                    queue_set(pick_set_size(), 0);
                // long result stall while points keep coming
                if (reg_i == 2 && ph == TOL_TOP)
                    hold_token++;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
